// ===== rtl/core/gsa_pkg.sv =====
`default_nettype none

package gsa_pkg;

    localparam int unsigned SLOT_IDX_BITS = 4;
    localparam int unsigned REQ_GEN_BITS  = 32;

    typedef enum logic {
        OP_RESERVE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_IGNORED   = 2'd2
    } t_status;

    typedef struct packed {
        t_op                       op;
        logic [SLOT_IDX_BITS-1:0]  slot_index;
        logic [REQ_GEN_BITS-1:0]   request_generation;
    } t_in_word;

    typedef struct packed {
        t_status                   status;
        logic [SLOT_IDX_BITS-1:0]  granted_index;
        logic [REQ_GEN_BITS-1:0]   granted_generation;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/core/gsa_free_finder.sv =====
`default_nettype none

module gsa_free_finder #(
    parameter int unsigned SLOT_COUNT = 16
) (
    input  wire logic [SLOT_COUNT-1:0]         i_busy,
    output logic                               o_found,
    output logic [$clog2(SLOT_COUNT)-1:0]      o_index
);

    localparam int unsigned AW = $clog2(SLOT_COUNT);

    // lowest clear bit wins
    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!i_busy[i]) begin
                o_found = 1'b1;
                o_index = AW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/generational_slot_allocator_top.sv =====
`default_nettype none

// Generational slot allocator. Each input word is handled as a read of the slot's
// generation from the on-chip generation memory, then a check or bump of it with a
// write-back. The result sits in an output register, so a stalled result does not
// hold up the read of the next word once that result is taken. Slot zero is reserved.
// Generation memory entries that were never written read as zero by way of a
// high-water mark, so no clearing pass follows reset and the first word may arrive
// right away.
module generational_slot_allocator_top #(
    parameter int unsigned SLOT_COUNT = 16,
    parameter int unsigned GEN_BITS   = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gsa_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gsa_pkg::t_out_word      o_out_word
);

    import gsa_pkg::*;

    localparam int unsigned AW = $clog2(SLOT_COUNT);
    localparam int unsigned XW = AW + SLOT_IDX_BITS;
    localparam int unsigned FW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [SLOT_COUNT-1:0]  r_busy, n_busy;
    logic [FW-1:0]          r_fill, n_fill;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_word, n_out_word;

    t_op                    r_op;
    logic [AW-1:0]          r_addr;
    logic                   r_found;
    logic                   r_fresh;
    logic                   r_idx_ok;
    logic [REQ_GEN_BITS-1:0] r_req_gen;

    logic [GEN_BITS-1:0]    r_gen_mem [SLOT_COUNT];
    logic [GEN_BITS-1:0]    r_rd_data;

    logic                   free_found;
    logic [AW-1:0]          free_index;
    logic                   accept;
    logic                   out_free;
    logic [XW-1:0]          idx_ext;
    logic [AW-1:0]          rd_addr;
    logic                   rd_fresh;
    logic [GEN_BITS-1:0]    gen_cur;
    logic [GEN_BITS-1:0]    gen_next;
    logic                   wr_en;
    logic                   rel_ok;

    gsa_free_finder #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_free_finder (
        .i_busy  (r_busy),
        .o_found (free_found),
        .o_index (free_index)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_ext  = XW'(i_in_word.slot_index);
    assign rd_addr  = (i_in_word.op == OP_RESERVE) ? free_index : idx_ext[AW-1:0];
    assign rd_fresh = XW'(rd_addr) >= XW'(r_fill);

    assign gen_cur  = r_fresh ? '0 : r_rd_data;
    assign gen_next = gen_cur + GEN_BITS'(1);
    assign rel_ok   = r_idx_ok && r_busy[r_addr]
                      && (REQ_GEN_BITS'(gen_cur) == r_req_gen);
    assign wr_en    = (r_state == S_EXEC) && out_free
                      && (r_op == OP_RESERVE) && r_found;

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_in_word.op;
            r_addr    <= rd_addr;
            r_found   <= free_found;
            r_fresh   <= rd_fresh;
            r_idx_ok  <= (idx_ext != '0) && (idx_ext < XW'(SLOT_COUNT));
            r_req_gen <= i_in_word.request_generation;
        end
    end

    // generation memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_gen_mem[r_addr] <= gen_next;
        end
        if (accept) begin
            r_rd_data <= r_gen_mem[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_word  = '{status: ST_DONE, granted_index: '0,
                                    granted_generation: '0};
                    if (r_op == OP_RESERVE) begin
                        if (r_found) begin
                            n_busy[r_addr] = 1'b1;
                            if (r_fresh) begin
                                n_fill = r_fill + FW'(1);
                            end
                            n_out_word.granted_index =
                                SLOT_IDX_BITS'(XW'(r_addr));
                            n_out_word.granted_generation =
                                REQ_GEN_BITS'(gen_next);
                        end else begin
                            n_out_word.status = ST_EXHAUSTED;
                        end
                    end else begin
                        if (rel_ok) begin
                            n_busy[r_addr] = 1'b0;
                        end else begin
                            n_out_word.status = ST_IGNORED;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= SLOT_COUNT'(1);
            r_fill      <= FW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

endmodule

`default_nettype wire
